[src/pps_pkg.sv]
// Package for the preemptive priority scheduler: queue geometry, entry type,
// request codes and a saturating end-time function. No dependencies.
package pps_pkg;
    localparam int QueueDepth = 16;
    localparam int QIdxW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    localparam logic REQ_ARRIVAL  = 1'b0;
    localparam logic REQ_COMPLETE = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [15:0] total;
        logic [15:0] remaining;
        logic [7:0]  priority_num;
    } t_entry;

    localparam int EntryW = $bits(t_entry);

    function automatic logic [31:0] sat_end(input logic [31:0] start,
                                            input logic [15:0] rem);
        logic [32:0] s;
        s = {1'b0, start} + {17'd0, rem};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction
endpackage

[src/pps_ram.sv]
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module pps_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/priority_preemptive_scheduler.sv]
// Top level of the preemptive priority scheduler: running task registers,
// ready queue in one pps_ram. Depends on pps_pkg and pps_ram.
//
//  channel | handshake             | payload
//  in      | i_valid / o_ready     | i_req_type .. i_new_priority
//  out     | o_valid / i_ready     | o_run_id .. o_dropped
//
// Arrival: decided and the queue entry written at the transfer; result the cycle after.
// Completion: one queue read per cycle for the minimum search, a dispatch state,
// then one entry moved per cycle; the search and the shift run entry by entry
// on the single queue RAM port pair.
// Reset clears the running task, the queue count and the handshakes; the RAM is not cleared.
// One item at a time; a result waiting on i_ready holds off the next item.
module priority_preemptive_scheduler
    import pps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_now_time,
    input  logic [15:0] i_new_id,
    input  logic [31:0] i_new_arrival,
    input  logic [15:0] i_new_total_burst,
    input  logic [15:0] i_new_remaining,
    input  logic [7:0]  i_new_priority,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_run_id,
    output logic [31:0] o_run_arrival,
    output logic [15:0] o_run_total_burst,
    output logic [31:0] o_run_start,
    output logic [31:0] o_run_end,
    output logic [15:0] o_run_remaining,
    output logic [7:0]  o_run_priority,
    output logic        o_dropped
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DISP  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    t_entry       r_cur;
    logic [31:0]  r_cur_start, r_cur_end;
    logic [QCntW-1:0] r_count;
    logic [31:0]  r_now;
    logic         r_dropped;
    logic [QCntW-1:0] r_idx;        // scan: read address issued last cycle; shift: destination
    logic [QIdxW-1:0] r_best;
    logic [7:0]   r_best_pri;
    t_entry       r_best_e;         // best entry captured as it streams past
    logic         r_have;
    logic         r_phase;          // shift: 0 = read issued, 1 = write

    logic             ram_we;
    logic [QIdxW-1:0] ram_waddr, ram_raddr;
    t_entry           ram_wdata, ram_rdata;

    pps_ram #(.Width(EntryW), .Depth(QueueDepth)) u_queue (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    logic in_xfer;
    logic full;
    logic [31:0] left_w;
    logic [15:0] left16;
    t_entry new_e;

    assign in_xfer = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign full    = (r_count == QCntW'(QueueDepth));
    assign left_w  = (r_cur_end > i_now_time) ? r_cur_end - i_now_time : 32'd0;
    assign left16  = (left_w[31:16] != 16'd0) ? 16'hFFFF : left_w[15:0];
    assign new_e   = '{id: i_new_id, arrival: i_new_arrival, total: i_new_total_burst,
                       remaining: i_new_remaining, priority_num: i_new_priority};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[QIdxW-1:0];
        ram_wdata = new_e;
        ram_raddr = r_idx[QIdxW-1:0];
        n_state   = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_req_type == REQ_COMPLETE) begin
                        ram_raddr = '0;
                        n_state   = (r_count == '0) ? S_OUT : S_SCAN;
                    end else begin
                        n_state = S_OUT;
                        if (r_cur.id != 16'd0 && !full) begin
                            ram_we = 1'b1;
                            if (r_cur.priority_num > i_new_priority) begin
                                ram_wdata = r_cur;
                                ram_wdata.remaining = left16;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                ram_raddr = r_idx[QIdxW-1:0] + 1'b1;
                if (r_idx + 1'b1 == r_count) n_state = S_DISP;
            end
            S_DISP: begin
                ram_raddr = r_best + 1'b1;
                n_state   = S_SHIFT;
            end
            S_SHIFT: begin
                // r_idx is the destination; data for r_idx+1 arrives when r_phase
                ram_raddr = r_idx[QIdxW-1:0] + 1'b1;
                if (r_idx + 1'b1 >= r_count) begin
                    n_state = S_OUT;
                end else if (r_phase) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[QIdxW-1:0];
                    ram_wdata = ram_rdata;
                    ram_raddr = r_idx[QIdxW-1:0] + 2'd2;
                end
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_cur_start <= '0;
            r_cur_end   <= '0;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_idx       <= '0;
            r_phase     <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_now     <= i_now_time;
                        r_dropped <= 1'b0;
                        r_idx     <= '0;
                        r_have    <= 1'b0;
                        if (i_req_type == REQ_COMPLETE) begin
                            if (r_count == '0) begin
                                r_cur       <= '0;
                                r_cur_start <= '0;
                                r_cur_end   <= '0;
                            end
                        end else if (r_cur.id == 16'd0 ||
                                     (r_cur.priority_num > i_new_priority && !full)) begin
                            if (r_cur.id != 16'd0) r_count <= r_count + 1'b1;
                            r_cur       <= new_e;
                            r_cur_start <= i_now_time;
                            r_cur_end   <= sat_end(i_now_time, i_new_remaining);
                        end else if (!full) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    // ram_rdata holds entry r_idx
                    if (!r_have || ram_rdata.priority_num < r_best_pri) begin
                        r_best     <= r_idx[QIdxW-1:0];
                        r_best_pri <= ram_rdata.priority_num;
                        r_have     <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_DISP: begin
                    r_cur       <= r_best_e;
                    r_cur_start <= r_now;
                    r_cur_end   <= sat_end(r_now, r_best_e.remaining);
                    r_idx       <= {1'b0, r_best};
                    r_phase     <= 1'b1;
                end
                S_SHIFT: begin
                    if (r_idx + 1'b1 >= r_count) begin
                        r_count <= r_count - 1'b1;
                    end else if (r_phase) begin
                        r_idx   <= r_idx + 1'b1;
                    end
                    r_phase <= 1'b1;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN &&
            (!r_have || ram_rdata.priority_num < r_best_pri)) begin
            r_best_e <= ram_rdata;
        end
    end

    assign o_run_id          = r_cur.id;
    assign o_run_arrival     = r_cur.arrival;
    assign o_run_total_burst = r_cur.total;
    assign o_run_start       = r_cur_start;
    assign o_run_end         = r_cur_end;
    assign o_run_remaining   = r_cur.remaining;
    assign o_run_priority    = r_cur.priority_num;
    assign o_dropped         = r_dropped;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCntW'(QueueDepth)) else $error("queue count overflow");
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_req_type == REQ_ARRIVAL && !full) |=> !r_dropped)
        else $error("drop with room in queue");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accepting while result pending");
endmodule
